// ===== rtl/core/pwmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmpd_pkg
// shared constants and types of the pwm period and duty programmer
// ----------------------------------------------------------------------------
`default_nettype none

package pwmpd_pkg;

    // table and clock setup
    localparam int NUM_SLOTS      = 16;
    localparam int CLOCK_HZ       = 24000000;
    localparam int PRESCALE_STEPS = 8;

    // field widths
    localparam int SLOT_W = 4;
    localparam int CH_W   = 2;
    localparam int VAL_W  = 18;
    localparam int FREQ_W = 24;
    localparam int RES_W  = 5;
    localparam int PRE_W  = 4;
    localparam int MOD_W  = 16;
    localparam int EN_W   = 3;

    // clamped duty spans 0..2^16
    localparam int DUTY_W = 17;
    // serial multiplier product: duty times modulo
    localparam int MUL_W  = DUTY_W + MOD_W;
    // clock quotient and divider dividend
    localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
    localparam int DVD_W  = (CLK_W > 32) ? CLK_W : 32;
    localparam int CNT_W  = $clog2(DVD_W);

    localparam logic [MOD_W-1:0]  MOD_MAX    = 16'hFFFF;
    localparam logic [MOD_W-1:0]  MOD_MIN    = 16'd2;
    localparam logic [RES_W-1:0]  RES_MIN    = 5'd1;
    localparam logic [RES_W-1:0]  RES_MAX    = 5'd16;
    localparam logic [RES_W-1:0]  RES_RESET  = 5'd8;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd1000;

    // operation codes
    localparam logic OP_DUTY = 1'b0;
    localparam logic OP_FREQ = 1'b1;

    // channel codes
    localparam logic [CH_W-1:0] CH_A = 2'd0;
    localparam logic [CH_W-1:0] CH_B = 2'd1;
    localparam logic [CH_W-1:0] CH_X = 2'd2;

    // enable bits
    localparam logic [EN_W-1:0] EN_X = 3'b001;
    localparam logic [EN_W-1:0] EN_B = 3'b010;
    localparam logic [EN_W-1:0] EN_A = 3'b100;

    // one table entry, modulo zero means not configured
    typedef struct packed {
        logic [MOD_W-1:0] modulo;
        logic [PRE_W-1:0] prescale;
        logic [MOD_W-1:0] cmp_x;
        logic [MOD_W-1:0] cmp_a;
        logic [MOD_W-1:0] cmp_b;
        logic [EN_W-1:0]  enables;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/core/pwm_period_duty_programmer_unit.sv =====
// ----------------------------------------------------------------------------
// pwm_period_duty_programmer_unit
// per-slot prescale, period and compare calculator for pwm submodules
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------------
//  request  | i_op i_slot i_channel i_value i_frequency | i_in_valid/o_in_stall
//  result   | o_slot_out .. o_reconfigured              | o_out_valid/i_out_stall
//  config   | i_cfg_data (resolution_bits)              | i_cfg_valid/o_cfg_ready
//
//  one word is worked at a time; a duty on a configured slot runs the
//  bit-serial multiplier, a duty on an unconfigured slot first the restoring
//  divider (one quotient bit a cycle) and the prescale search, and a
//  frequency change runs the divide and prescale search, then on a configured
//  slot three multiply and divide rescales
//  synchronous active-low reset clears the slot table at once, no sweep
//  a result waits in the output register under i_out_stall while the next
//  request word is taken
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_period_duty_programmer_unit
    import pwmpd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic [SLOT_W-1:0]        i_slot,
    input  logic [CH_W-1:0]          i_channel,
    input  logic signed [VAL_W-1:0]  i_value,
    input  logic [FREQ_W-1:0]        i_frequency,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [SLOT_W-1:0]        o_slot_out,
    output logic [PRE_W-1:0]         o_prescale,
    output logic [MOD_W-1:0]         o_period_value,
    output logic [MOD_W-1:0]         o_compare_x,
    output logic [MOD_W-1:0]         o_compare_a,
    output logic [MOD_W-1:0]         o_compare_b,
    output logic [EN_W-1:0]          o_channel_enables,
    output logic                     o_reconfigured,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [RES_W-1:0]         i_cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVC  = 3'd1;  // clock / frequency
    localparam logic [2:0] ST_PRESC = 3'd2;  // prescale search
    localparam logic [2:0] ST_MULD  = 3'd3;  // duty times modulo
    localparam logic [2:0] ST_MULR  = 3'd4;  // compare times new modulo
    localparam logic [2:0] ST_DIVR  = 3'd5;  // product / old modulo
    localparam logic [2:0] ST_FIN   = 3'd6;  // write back, present result

    // working compare index
    localparam logic [1:0] CMP_X = 2'd0;
    localparam logic [1:0] CMP_A = 2'd1;
    localparam logic [1:0] CMP_B = 2'd2;

    logic [2:0]         r_state;
    t_entry             r_tbl [NUM_SLOTS];
    logic [RES_W-1:0]   r_res;
    logic [FREQ_W-1:0]  r_cur_freq;

    // item being worked
    logic               r_op;
    logic [SLOT_W-1:0]  r_slot;
    logic [CH_W-1:0]    r_ch;
    logic [DUTY_W-1:0]  r_v;
    logic               r_ignore;
    logic               r_recfg;
    logic [MOD_W-1:0]   r_m_old;
    logic [MOD_W-1:0]   r_m;
    logic [PRE_W-1:0]   r_pre;
    logic [MOD_W-1:0]   r_cmp [3];
    logic [EN_W-1:0]    r_en;
    logic [CLK_W-1:0]   r_q;
    logic [1:0]         r_idx;
    logic [CNT_W-1:0]   r_cnt;

    // serial multiplier
    logic [MUL_W-1:0]   r_mc;
    logic [MOD_W-1:0]   r_mp;
    logic [MUL_W-1:0]   r_acc;
    logic [MUL_W-1:0]   n_acc;

    // restoring divider, r_dq holds the dividend and fills with quotient bits
    logic [DVD_W-1:0]   r_dq;
    logic [FREQ_W-1:0]  r_rem;
    logic [FREQ_W-1:0]  r_dvs;
    logic [DVD_W-1:0]   n_dq;
    logic [FREQ_W-1:0]  n_rem;
    logic [FREQ_W:0]    div_shift;
    logic [FREQ_W:0]    div_diff;
    logic               div_ge;

    // output register
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [PRE_W-1:0]   r_o_pre;
    logic [MOD_W-1:0]   r_o_period;
    logic [MOD_W-1:0]   r_o_cx;
    logic [MOD_W-1:0]   r_o_ca;
    logic [MOD_W-1:0]   r_o_cb;
    logic [EN_W-1:0]    r_o_en;
    logic               r_o_recfg;

    // request side helpers
    logic               in_acc;
    t_entry             tbl_rd;
    logic [DUTY_W-1:0]  range;
    logic [DUTY_W-1:0]  v_clamp;
    logic [FREQ_W-1:0]  f_eff;
    logic               slot_bad;

    // prescale search and duty
    logic               presc_fit;
    logic               presc_last;
    logic [MOD_W-1:0]   mod_sel;
    logic [MOD_W-1:0]   duty;
    logic [1:0]         idx_nxt;
    logic               out_free;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        tbl_rd   = r_tbl[i_slot];
        slot_bad = (32'(i_slot) >= NUM_SLOTS);
        range    = DUTY_W'(1) << r_res;
        // negative requests read as zero, large ones as full scale
        if (i_value[VAL_W-1]) begin
            v_clamp = '0;
        end else if (i_value[DUTY_W-1:0] > range) begin
            v_clamp = range;
        end else begin
            v_clamp = i_value[DUTY_W-1:0];
        end
        f_eff = (i_frequency == '0) ? FREQ_W'(1) : i_frequency;
    end

    // one shift-add step and one restoring divide step per cycle
    always_comb begin
        n_acc     = r_mp[0] ? (r_acc + r_mc) : r_acc;
        div_shift = {r_rem, r_dq[DVD_W-1]};
        div_ge    = (div_shift >= {1'b0, r_dvs});
        div_diff  = div_shift - {1'b0, r_dvs};
        n_rem     = div_ge ? div_diff[FREQ_W-1:0] : div_shift[FREQ_W-1:0];
        n_dq      = {r_dq[DVD_W-2:0], div_ge};
    end

    always_comb begin
        presc_fit  = (r_q[CLK_W-1:MOD_W] == '0);
        presc_last = (r_pre == PRE_W'(PRESCALE_STEPS - 1));
        if (presc_fit) begin
            mod_sel = (r_q[MOD_W-1:0] < MOD_MIN) ? MOD_MIN : r_q[MOD_W-1:0];
        end else begin
            mod_sel = MOD_MAX;
        end
        duty    = MOD_W'(n_acc >> r_res);
        idx_nxt = r_idx + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_res       <= RES_RESET;
            r_cur_freq  <= FREQ_RESET;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_tbl[i] <= '0;
            end
        end else begin
            // resolution register, clamped to 1..16
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_data < RES_MIN) begin
                    r_res <= RES_MIN;
                end else if (i_cfg_data > RES_MAX) begin
                    r_res <= RES_MAX;
                end else begin
                    r_res <= i_cfg_data;
                end
            end

            // a new result refills the register as the old one leaves
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op       <= i_op;
                        r_slot     <= i_slot;
                        r_ch       <= i_channel;
                        r_v        <= v_clamp;
                        r_ignore   <= slot_bad;
                        r_m_old    <= tbl_rd.modulo;
                        r_m        <= tbl_rd.modulo;
                        r_pre      <= tbl_rd.prescale;
                        r_cmp[CMP_X] <= tbl_rd.cmp_x;
                        r_cmp[CMP_A] <= tbl_rd.cmp_a;
                        r_cmp[CMP_B] <= tbl_rd.cmp_b;
                        r_en       <= tbl_rd.enables;
                        r_dq       <= DVD_W'(CLOCK_HZ);
                        r_rem      <= '0;
                        r_acc      <= '0;
                        r_mc       <= MUL_W'(v_clamp);
                        r_mp       <= tbl_rd.modulo;
                        if (slot_bad) begin
                            r_recfg <= 1'b0;
                            r_state <= ST_FIN;
                        end else if (i_op == OP_FREQ) begin
                            r_cur_freq <= f_eff;
                            r_dvs      <= f_eff;
                            r_recfg    <= 1'b1;
                            r_cnt      <= CNT_W'(DVD_W - 1);
                            r_state    <= ST_DIVC;
                        end else if (tbl_rd.modulo == '0) begin
                            // first duty on an unconfigured slot
                            r_dvs   <= r_cur_freq;
                            r_recfg <= 1'b1;
                            r_cnt   <= CNT_W'(DVD_W - 1);
                            r_state <= ST_DIVC;
                        end else begin
                            r_recfg <= 1'b0;
                            r_cnt   <= CNT_W'(MOD_W - 1);
                            r_state <= ST_MULD;
                        end
                    end
                end

                ST_DIVC: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_q     <= n_dq[CLK_W-1:0];
                        r_pre   <= '0;
                        r_state <= ST_PRESC;
                    end
                end

                ST_PRESC: begin
                    if (presc_fit || presc_last) begin
                        r_m   <= mod_sel;
                        r_acc <= '0;
                        r_mp  <= mod_sel;
                        r_cnt <= CNT_W'(MOD_W - 1);
                        if (!presc_fit) begin
                            r_pre <= PRE_W'(PRESCALE_STEPS);
                        end
                        if (r_op == OP_DUTY) begin
                            r_mc    <= MUL_W'(r_v);
                            r_state <= ST_MULD;
                        end else if (r_m_old != '0) begin
                            r_idx   <= CMP_X;
                            r_mc    <= MUL_W'(r_cmp[CMP_X]);
                            r_state <= ST_MULR;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end else begin
                        // next prescale halves the quotient
                        r_q   <= r_q >> 1;
                        r_pre <= r_pre + 1'b1;
                    end
                end

                ST_MULD: begin
                    r_acc <= n_acc;
                    r_mc  <= r_mc << 1;
                    r_mp  <= r_mp >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        case (r_ch)
                            CH_A: begin
                                r_cmp[CMP_A] <= duty;
                                r_en         <= r_en | EN_A;
                            end
                            CH_B: begin
                                r_cmp[CMP_B] <= duty;
                                r_en         <= r_en | EN_B;
                            end
                            CH_X: begin
                                // inverted sense, stores off-time
                                r_cmp[CMP_X] <= r_m - duty;
                                r_en         <= r_en | EN_X;
                            end
                            default: begin
                                // unused channel code leaves compares alone
                            end
                        endcase
                        r_state <= ST_FIN;
                    end
                end

                ST_MULR: begin
                    r_acc <= n_acc;
                    r_mc  <= r_mc << 1;
                    r_mp  <= r_mp >> 1;
                    if (r_cnt == '0) begin
                        r_dq    <= n_acc[DVD_W-1:0];
                        r_rem   <= '0;
                        r_dvs   <= FREQ_W'(r_m_old);
                        r_cnt   <= CNT_W'(DVD_W - 1);
                        r_state <= ST_DIVR;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end

                ST_DIVR: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    if (r_cnt == '0) begin
                        r_cmp[r_idx] <= n_dq[MOD_W-1:0];
                        if (r_idx == CMP_B) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_idx   <= idx_nxt;
                            r_acc   <= '0;
                            r_mc    <= MUL_W'(r_cmp[idx_nxt]);
                            r_mp    <= r_m;
                            r_cnt   <= CNT_W'(MOD_W - 1);
                            r_state <= ST_MULR;
                        end
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end

                ST_FIN: begin
                    if (out_free) begin
                        r_o_slot    <= r_slot;
                        if (r_ignore) begin
                            // slot outside the table reports zeros
                            r_o_pre    <= '0;
                            r_o_period <= '0;
                            r_o_cx     <= '0;
                            r_o_ca     <= '0;
                            r_o_cb     <= '0;
                            r_o_en     <= '0;
                            r_o_recfg  <= 1'b0;
                        end else begin
                            r_o_pre    <= r_pre;
                            r_o_period <= r_m - 1'b1;
                            r_o_cx     <= r_cmp[CMP_X];
                            r_o_ca     <= r_cmp[CMP_A];
                            r_o_cb     <= r_cmp[CMP_B];
                            r_o_en     <= r_en;
                            r_o_recfg  <= r_recfg;
                            r_tbl[r_slot] <= '{modulo:   r_m,
                                               prescale: r_pre,
                                               cmp_x:    r_cmp[CMP_X],
                                               cmp_a:    r_cmp[CMP_A],
                                               cmp_b:    r_cmp[CMP_B],
                                               enables:  r_en};
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_slot_out        = r_o_slot;
    assign o_prescale        = r_o_pre;
    assign o_period_value    = r_o_period;
    assign o_compare_x       = r_o_cx;
    assign o_compare_a       = r_o_ca;
    assign o_compare_b       = r_o_cb;
    assign o_channel_enables = r_o_en;
    assign o_reconfigured    = r_o_recfg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_pwm_period_duty_programmer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pwm_period_duty_programmer_unit
// self-checking bench for the pwm period and duty programmer
// ----------------------------------------------------------------------------
// request words go in over valid/stall and come back as one settings word
// each; a behavioral copy of the slot table predicts every settings word,
// and a few directed rows carry hand-written settings instead.
// the run walks several duty resolutions, with random idling on both sides,
// one long output hold-off and one stretch with no idling at all
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pwm_period_duty_programmer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pwmpd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 4;
    // longest request is a frequency change with three rescales
    localparam int DRAIN_CYCLES   = 400;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PHASES         = 7;
    localparam int WORDS_PER_PHASE = 270;
    localparam int MAX_REPORTS    = 40;
    // slowest correct run is well under 2 ms
    localparam int RUN_LIMIT_NS   = 8_000_000;

    // channel code that touches no compare and no enable
    localparam logic [CH_W-1:0] CH_NONE = 2'd3;

    // one settings word as the block reports it
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [PRE_W-1:0]  prescale;
        logic [MOD_W-1:0]  period;
        logic [MOD_W-1:0]  cmp_x;
        logic [MOD_W-1:0]  cmp_a;
        logic [MOD_W-1:0]  cmp_b;
        logic [EN_W-1:0]   enables;
        logic              reconfigured;
    } t_slot_settings;

    // one request word, with an optional hand-written settings word
    typedef struct packed {
        logic                    op;
        logic [SLOT_W-1:0]       slot;
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] value;
        logic [FREQ_W-1:0]       frequency;
        logic                    fixed;
        t_slot_settings          want;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_op;
    logic [SLOT_W-1:0]       i_slot;
    logic [CH_W-1:0]         i_channel;
    logic signed [VAL_W-1:0] i_value;
    logic [FREQ_W-1:0]       i_frequency;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [SLOT_W-1:0]       o_slot_out;
    logic [PRE_W-1:0]        o_prescale;
    logic [MOD_W-1:0]        o_period_value;
    logic [MOD_W-1:0]        o_compare_x;
    logic [MOD_W-1:0]        o_compare_a;
    logic [MOD_W-1:0]        o_compare_b;
    logic [EN_W-1:0]         o_channel_enables;
    logic                    o_reconfigured;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [RES_W-1:0]        i_cfg_data;

    // travels with the request word so the monitor sees it at the same edge
    logic                    word_fixed;
    t_slot_settings          word_want;

    // behavioral copy of the block state
    logic [RES_W-1:0]  res_bits;
    logic [FREQ_W-1:0] run_freq;
    logic [MOD_W-1:0]  mod_tab   [NUM_SLOTS];
    logic [PRE_W-1:0]  pre_tab   [NUM_SLOTS];
    logic [MOD_W-1:0]  cmp_x_tab [NUM_SLOTS];
    logic [MOD_W-1:0]  cmp_a_tab [NUM_SLOTS];
    logic [MOD_W-1:0]  cmp_b_tab [NUM_SLOTS];
    logic [EN_W-1:0]   en_tab    [NUM_SLOTS];

    t_slot_settings settings_due [$];
    t_stim_row      directed_plan [22];

    int mismatch_count = 0;
    int in_idle_pct    = 6;
    int out_idle_pct   = 6;
    int holdoff_len    = 0;

    pwm_period_duty_programmer_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_slot            (i_slot),
        .i_channel         (i_channel),
        .i_value           (i_value),
        .i_frequency       (i_frequency),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_slot_out        (o_slot_out),
        .o_prescale        (o_prescale),
        .o_period_value    (o_period_value),
        .o_compare_x       (o_compare_x),
        .o_compare_a       (o_compare_a),
        .o_compare_b       (o_compare_b),
        .o_channel_enables (o_channel_enables),
        .o_reconfigured    (o_reconfigured),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // smallest prescale whose quotient fits the 16-bit counter, then clamp
    function automatic void configure_entry(logic [SLOT_W-1:0] s);
        longint unsigned clk_hz;
        longint unsigned f;
        longint unsigned q;
        int p;
        clk_hz = CLOCK_HZ;
        f = run_freq;
        p = 0;
        q = clk_hz / f;
        // when nothing fits, p ends one past the last step and q keeps the
        // quotient of the last step
        while (q > MOD_MAX && p < PRESCALE_STEPS) begin
            p = p + 1;
            if (p < PRESCALE_STEPS)
                q = clk_hz / ((64'd1 << p) * f);
        end
        if (q < MOD_MIN)
            q = MOD_MIN;
        if (q > MOD_MAX)
            q = MOD_MAX;
        pre_tab[s] = p[PRE_W-1:0];
        mod_tab[s] = q[MOD_W-1:0];
    endfunction

    function automatic logic [MOD_W-1:0] scale_compare(logic [MOD_W-1:0] v,
                                                       logic [MOD_W-1:0] new_mod,
                                                       logic [MOD_W-1:0] old_mod);
        longint unsigned t;
        t = v;
        t = t * new_mod / old_mod;
        return t[MOD_W-1:0];
    endfunction

    // applies one request word to the table copy and returns its settings word
    function automatic t_slot_settings program_slot(logic op, logic [SLOT_W-1:0] s,
                                                    logic [CH_W-1:0] ch,
                                                    logic signed [VAL_W-1:0] val,
                                                    logic [FREQ_W-1:0] f);
        t_slot_settings r;
        longint unsigned span;
        longint unsigned level;
        longint unsigned duty;
        longint unsigned inverted;
        logic [MOD_W-1:0] old_mod;
        r = '0;
        r.slot = s;
        if (s >= NUM_SLOTS)
            return r;
        if (op == OP_DUTY) begin
            span = 64'd1 << res_bits;
            if (val < 0)
                level = 0;
            else
                level = val;
            if (level > span)
                level = span;
            if (mod_tab[s] == '0) begin
                configure_entry(s);
                r.reconfigured = 1'b1;
            end
            duty = level * mod_tab[s] / span;
            case (ch)
                CH_A: begin
                    cmp_a_tab[s] = duty[MOD_W-1:0];
                    en_tab[s] = en_tab[s] | EN_A;
                end
                CH_B: begin
                    cmp_b_tab[s] = duty[MOD_W-1:0];
                    en_tab[s] = en_tab[s] | EN_B;
                end
                CH_X: begin
                    inverted = mod_tab[s] - duty;
                    cmp_x_tab[s] = inverted[MOD_W-1:0];
                    en_tab[s] = en_tab[s] | EN_X;
                end
                default: ;
            endcase
        end else begin
            old_mod = mod_tab[s];
            if (f == '0)
                run_freq = FREQ_W'(1);
            else
                run_freq = f;
            configure_entry(s);
            r.reconfigured = 1'b1;
            // compares of a fresh slot stay as they are
            if (old_mod != '0) begin
                cmp_x_tab[s] = scale_compare(cmp_x_tab[s], mod_tab[s], old_mod);
                cmp_a_tab[s] = scale_compare(cmp_a_tab[s], mod_tab[s], old_mod);
                cmp_b_tab[s] = scale_compare(cmp_b_tab[s], mod_tab[s], old_mod);
            end
        end
        r.prescale = pre_tab[s];
        r.period   = mod_tab[s] - 1'b1;
        r.cmp_x    = cmp_x_tab[s];
        r.cmp_a    = cmp_a_tab[s];
        r.cmp_b    = cmp_b_tab[s];
        r.enables  = en_tab[s];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s at %0t ns: got %0d, expected %0d",
                     what, $time, got_v, want_v);
    endtask

    // ------------------------------------------------------------------------
    // monitor: checks settings words, predicts on accepted requests and
    // tracks resolution writes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : settings_monitor
        t_slot_settings got_w;
        t_slot_settings want_w;
        t_slot_settings calc_w;
        if (i_rst_n) begin
            // output side first: a word leaving now belongs to an older request
            if (o_out_valid && !i_out_stall) begin
                got_w = {o_slot_out, o_prescale, o_period_value, o_compare_x,
                         o_compare_a, o_compare_b, o_channel_enables, o_reconfigured};
                if (settings_due.size() == 0) begin
                    report_mismatch("settings word with none pending, slot",
                                    got_w.slot, 0);
                end else begin
                    want_w = settings_due.pop_front();
                    if (got_w.slot !== want_w.slot)
                        report_mismatch("slot_out", got_w.slot, want_w.slot);
                    if (got_w.prescale !== want_w.prescale)
                        report_mismatch("prescale", got_w.prescale, want_w.prescale);
                    if (got_w.period !== want_w.period)
                        report_mismatch("period_value", got_w.period, want_w.period);
                    if (got_w.cmp_x !== want_w.cmp_x)
                        report_mismatch("compare_x", got_w.cmp_x, want_w.cmp_x);
                    if (got_w.cmp_a !== want_w.cmp_a)
                        report_mismatch("compare_a", got_w.cmp_a, want_w.cmp_a);
                    if (got_w.cmp_b !== want_w.cmp_b)
                        report_mismatch("compare_b", got_w.cmp_b, want_w.cmp_b);
                    if (got_w.enables !== want_w.enables)
                        report_mismatch("channel_enables", got_w.enables, want_w.enables);
                    if (got_w.reconfigured !== want_w.reconfigured)
                        report_mismatch("reconfigured", got_w.reconfigured,
                                        want_w.reconfigured);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                // the table copy advances even when the row carries its own answer
                calc_w = program_slot(i_op, i_slot, i_channel, i_value, i_frequency);
                if (word_fixed)
                    settings_due.push_back(word_want);
                else
                    settings_due.push_back(calc_w);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_data < RES_MIN)
                    res_bits = RES_MIN;
                else if (i_cfg_data > RES_MAX)
                    res_bits = RES_MAX;
                else
                    res_bits = i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, or one long hold-off when asked for
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int span_left;
        logic stall_now;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_len > 0) begin
                span_left = holdoff_len;
                holdoff_len = 0;
                i_out_stall <= 1'b1;
                // block fills up behind this and must stall its input
                repeat (span_left) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                stall_now = (out_idle_pct > 0) && ($urandom_range(99) < out_idle_pct);
                i_out_stall <= stall_now;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offers one request word and returns at the edge that takes it;
    // valid stays high into the next word unless a random gap is drawn
    task automatic send_word(t_stim_row w);
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= w.op;
        i_slot      <= w.slot;
        i_channel   <= w.channel;
        i_value     <= w.value;
        i_frequency <= w.frequency;
        word_fixed  <= w.fixed;
        word_want   <= w.want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // resolution write, only issued while nothing is in flight
    task automatic write_resolution(logic [RES_W-1:0] bits);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bits;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_stim_row r;
        logic [RES_W-1:0] cfg_plan [PHASES];
        int ph;
        int n;
        int span;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= OP_DUTY;
        i_slot      <= '0;
        i_channel   <= CH_A;
        i_value     <= '0;
        i_frequency <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        word_fixed  <= 1'b0;
        word_want   <= '0;

        res_bits = RES_RESET;
        run_freq = FREQ_RESET;
        for (n = 0; n < NUM_SLOTS; n++) begin
            mod_tab[n]   = '0;
            pre_tab[n]   = '0;
            cmp_x_tab[n] = '0;
            cmp_a_tab[n] = '0;
            cmp_b_tab[n] = '0;
            en_tab[n]    = '0;
        end

        // directed rows at the reset resolution of 8 bits; rows with fixed set
        // carry a settings word worked out by hand
        directed_plan = '{
            // fresh slot at 1000 Hz: prescale 0, modulo 24000
            '{OP_DUTY, 4'd0, CH_A, 18'd0, 24'd0, 1'b1,
              '{4'd0, 4'd0, 16'd23999, 16'd0, 16'd0, 16'd0, EN_A, 1'b1}},
            // full scale on B gives the whole modulo
            '{OP_DUTY, 4'd0, CH_B, 18'd256, 24'd0, 1'b1,
              '{4'd0, 4'd0, 16'd23999, 16'd0, 16'd0, 16'd24000, EN_A | EN_B, 1'b0}},
            // largest positive duty clamps to full scale, X stores modulo minus duty
            '{OP_DUTY, 4'd0, CH_X, 18'h1FFFF, 24'd0, 1'b1,
              '{4'd0, 4'd0, 16'd23999, 16'd0, 16'd0, 16'd24000,
                EN_A | EN_B | EN_X, 1'b0}},
            // most negative duty reads as zero
            '{OP_DUTY, 4'd0, CH_A, 18'h20000, 24'd0, 1'b1,
              '{4'd0, 4'd0, 16'd23999, 16'd0, 16'd0, 16'd24000,
                EN_A | EN_B | EN_X, 1'b0}},
            '{OP_DUTY, 4'd0, CH_A, 18'd128, 24'd0, 1'b0, '0},
            '{OP_DUTY, 4'd0, CH_B, 18'h3FFFF, 24'd0, 1'b0, '0},
            '{OP_DUTY, 4'd0, CH_X, 18'd257, 24'd0, 1'b0, '0},
            // channel code 3 leaves the compares alone
            '{OP_DUTY, 4'd0, CH_NONE, 18'd100, 24'd0, 1'b0, '0},
            // channel code 3 on a fresh slot still configures it
            '{OP_DUTY, 4'd1, CH_NONE, 18'd5, 24'd0, 1'b1,
              '{4'd1, 4'd0, 16'd23999, 16'd0, 16'd0, 16'd0, 3'b000, 1'b1}},
            // zero frequency reads as 1 Hz: no prescale fits, modulo clamps high
            '{OP_FREQ, 4'd2, CH_A, 18'd0, 24'd0, 1'b1,
              '{4'd2, 4'd8, 16'd65534, 16'd0, 16'd0, 16'd0, 3'b000, 1'b1}},
            '{OP_DUTY, 4'd2, CH_X, 18'd256, 24'd0, 1'b0, '0},
            '{OP_DUTY, 4'd2, CH_A, 18'd1, 24'd0, 1'b0, '0},
            // top frequency clamps the modulo low and rescales everything down
            '{OP_FREQ, 4'd2, CH_A, 18'd0, 24'hFFFFFF, 1'b0, '0},
            '{OP_FREQ, 4'd0, CH_A, 18'd0, 24'd1000, 1'b0, '0},
            '{OP_FREQ, 4'd0, CH_B, 18'd0, 24'd50, 1'b0, '0},
            '{OP_FREQ, 4'd15, CH_A, 18'd0, 24'd366, 1'b0, '0},
            '{OP_DUTY, 4'd15, CH_A, 18'd200, 24'd0, 1'b0, '0},
            '{OP_FREQ, 4'd3, CH_A, 18'd0, 24'd2, 1'b0, '0},
            // fresh slot picks up the last frequency written elsewhere
            '{OP_DUTY, 4'd5, CH_B, 18'd255, 24'd0, 1'b0, '0},
            '{OP_FREQ, 4'd15, CH_A, 18'd0, 24'd12000000, 1'b0, '0},
            '{OP_FREQ, 4'd15, CH_A, 18'd0, 24'd6000000, 1'b0, '0},
            '{OP_DUTY, 4'd15, CH_X, 18'd128, 24'd0, 1'b0, '0}
        };

        // resolution per phase: all-zero and all-one writes clamp to the ends
        cfg_plan = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd12, 5'd0, 5'd8};
        cfg_plan[5] = RES_W'($urandom_range(31));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k])
            send_word(directed_plan[k]);
        i_in_valid <= 1'b0;

        for (ph = 0; ph < PHASES; ph++) begin
            // sender holds until every settings word is back, then reprograms
            while (settings_due.size() != 0) @(posedge i_clk);
            write_resolution(cfg_plan[ph]);

            // one phase runs with no idling at all
            in_idle_pct  = (ph == 2) ? 0 : 6;
            out_idle_pct = (ph == 2) ? 0 : 6;
            if (ph == 1)
                holdoff_len = HOLDOFF_CYCLES;

            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                r = '0;
                r.op = ($urandom_range(99) < 25) ? OP_FREQ : OP_DUTY;
                r.slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
                if ($urandom_range(9) == 0)
                    r.channel = CH_NONE;
                else
                    r.channel = CH_W'($urandom_range(2));
                span = 1 << res_bits;
                case ($urandom_range(7))
                    0: r.value = VAL_W'($urandom);
                    1: r.value = VAL_W'(0 - int'($urandom_range(1, 131072)));
                    2: r.value = VAL_W'(span + int'($urandom_range(0, 3)));
                    default: r.value = VAL_W'($urandom_range(0, span));
                endcase
                // spread over every octave of the 24-bit range
                r.frequency = FREQ_W'($urandom & ((32'd1 << $urandom_range(1, FREQ_W)) - 1));
                send_word(r);
            end
            i_in_valid <= 1'b0;
        end

        while (settings_due.size() != 0) @(posedge i_clk);
        // catch any stray word after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && settings_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/pwmpd_pkg.sv
rtl/core/pwm_period_duty_programmer_unit.sv
tb/sv/tb_pwm_period_duty_programmer_unit.sv
